>>> rtl/dcc_pkg.sv
package dcc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_PACKET_BYTES_DEF = 6;
  localparam int FIFO_PACKETS_DEF     = 16;

  // register reset values
  localparam logic [7:0] ONE_HALF_RESET  = 8'd58;
  localparam logic [7:0] ZERO_HALF_RESET = 8'd100;
  localparam logic [5:0] PREAMBLE_RESET  = 6'd22;

  // idle packet
  localparam int         IDLE_LENGTH = 3;
  localparam logic [7:0] IDLE_BYTE_0 = 8'hFF;
  localparam logic [7:0] IDLE_BYTE_1 = 8'h00;
  localparam logic [7:0] IDLE_BYTE_2 = 8'hFF;

  typedef enum logic [2:0] {
    ST_PREAMBLE,
    ST_START,
    ST_DATA,
    ST_GAP,
    ST_END
  } enc_state_t;

  typedef enum logic [1:0] {
    PUSH_NONE   = 2'd0,
    PUSH_OK     = 2'd1,
    PUSH_REJECT = 2'd2
  } push_status_t;

  typedef enum logic [2:0] {
    CFG_OUTPUT_ENABLE   = 3'd0,
    CFG_DRIVE_MODE      = 3'd1,
    CFG_ONE_HALF_TICKS  = 3'd2,
    CFG_ZERO_HALF_TICKS = 3'd3,
    CFG_PREAMBLE_LENGTH = 3'd4
  } cfg_index_t;

  // byte of the idle packet at a given position
  function automatic logic [7:0] idle_byte(input int unsigned idx);
    logic [7:0] b;
    unique case (idx)
      0:       b = IDLE_BYTE_0;
      1:       b = IDLE_BYTE_1;
      2:       b = IDLE_BYTE_2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/dcc_if.sv
// input channel: tick or packet-byte push
interface dcc_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [7:0] data_byte;
  logic last_byte;

  modport source (output valid, output op, output data_byte, output last_byte, input ready);
  modport sink (input valid, input op, input data_byte, input last_byte, output ready);
endinterface

// result channel: track levels and push status
interface dcc_out_if import dcc_pkg::*; #(
  parameter int QUEUE_W = $clog2(FIFO_PACKETS_DEF + 1)
);
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic half_phase;
  logic bit_on_track;
  push_status_t push_status;
  logic [QUEUE_W-1:0] queue_used;

  modport source (output valid, output pin_a, output pin_b, output half_phase,
                  output bit_on_track, output push_status, output queue_used,
                  input ready);
  modport sink (input valid, input pin_a, input pin_b, input half_phase,
                input bit_on_track, input push_status, input queue_used,
                output ready);
endinterface

>>> rtl/dcc_track_signal_generator.sv
// DCC track signal generator. Each transaction on the input channel is either a
// one-microsecond tick or a push of one packet byte; each gives exactly one
// result, registered, the cycle after it is accepted. A new transaction is taken
// every cycle while the result register is empty or being emptied, so the
// sustained rate is one item per clock. Pushed bytes go into a packet store of
// FIFO_PACKETS + 1 slots of MAX_PACKET_BYTES bytes (one memory, one write and one
// registered read port); the extra slot holds the packet now on the track. The
// store needs no clearing pass after reset. The encoder sends the preamble,
// start bits, bytes MSB first and the end bit, then moves to the next queued
// packet or the idle packet. Writing output_enable = 0 forces both pins low and
// returns the encoder to its start point; queued packets are kept.
module dcc_track_signal_generator import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int FIFO_PACKETS     = FIFO_PACKETS_DEF,
  localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1),
  localparam int CNT_W = $clog2(FIFO_PACKETS + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  dcc_in_if.sink     in_ch,
  dcc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic       enable_r;
  logic       mode_r;
  logic [7:0] one_half_r;
  logic [7:0] zero_half_r;
  logic [5:0] preamble_r;
  logic       home;

  logic             in_ready, accept, tick, push;
  logic             pop, nonempty;
  logic [LEN_W-1:0] rd_idx, head_len;
  logic [7:0]       rd_byte;
  push_status_t     push_status;
  logic [CNT_W-1:0] count_nxt;
  logic             pin_a, pin_b, half_phase, bit_on_track;

  logic             out_valid_r;
  logic             pin_a_r, pin_b_r, half_phase_r, bit_on_track_r;
  push_status_t     push_status_r;
  logic [CNT_W-1:0] queue_used_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      mode_r      <= 1'b0;
      one_half_r  <= ONE_HALF_RESET;
      zero_half_r <= ZERO_HALF_RESET;
      preamble_r  <= PREAMBLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OUTPUT_ENABLE:   enable_r    <= cfg_data[0];
        CFG_DRIVE_MODE:      mode_r      <= cfg_data[0];
        CFG_ONE_HALF_TICKS:  one_half_r  <= cfg_data;
        CFG_ZERO_HALF_TICKS: zero_half_r <= cfg_data;
        CFG_PREAMBLE_LENGTH: preamble_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign home = cfg_we && (cfg_index_t'(cfg_index) == CFG_OUTPUT_ENABLE) && !cfg_data[0];

  // input handshake
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign tick        = accept && !in_ch.op;
  assign push        = accept && in_ch.op;

  dcc_fifo #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .FIFO_PACKETS    (FIFO_PACKETS)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_byte  (in_ch.data_byte),
    .push_last  (in_ch.last_byte),
    .pop        (pop),
    .rd_idx     (rd_idx),
    .push_status(push_status),
    .count_nxt  (count_nxt),
    .nonempty   (nonempty),
    .head_len   (head_len),
    .rd_byte    (rd_byte)
  );

  dcc_encoder #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_encoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .enable      (enable_r),
    .drive_mode  (mode_r),
    .one_half    (one_half_r),
    .zero_half   (zero_half_r),
    .preamble_len(preamble_r),
    .home        (home),
    .nonempty    (nonempty),
    .head_len    (head_len),
    .rd_byte     (rd_byte),
    .pop         (pop),
    .rd_idx      (rd_idx),
    .pin_a       (pin_a),
    .pin_b       (pin_b),
    .half_phase  (half_phase),
    .bit_on_track(bit_on_track)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_a_r        <= pin_a;
      pin_b_r        <= pin_b;
      half_phase_r   <= half_phase;
      bit_on_track_r <= bit_on_track;
      push_status_r  <= push_status;
      queue_used_r   <= count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pin_a        = pin_a_r;
  assign out_ch.pin_b        = pin_b_r;
  assign out_ch.half_phase   = half_phase_r;
  assign out_ch.bit_on_track = bit_on_track_r;
  assign out_ch.push_status  = push_status_r;
  assign out_ch.queue_used   = queue_used_r;

endmodule

>>> rtl/dcc_fifo.sv
module dcc_fifo import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int FIFO_PACKETS     = FIFO_PACKETS_DEF,
  localparam int LEN_W  = $clog2(MAX_PACKET_BYTES + 1),
  localparam int CNT_W  = $clog2(FIFO_PACKETS + 1),
  localparam int SLOTS  = FIFO_PACKETS + 1,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int DEPTH  = SLOTS * MAX_PACKET_BYTES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [7:0]       push_byte,
  input  logic             push_last,
  input  logic             pop,
  input  logic [LEN_W-1:0] rd_idx,
  output push_status_t     push_status,
  output logic [CNT_W-1:0] count_nxt,
  output logic             nonempty,
  output logic [LEN_W-1:0] head_len,
  output logic [7:0]       rd_byte
);

  // one slot more than the queue holds, so the packet on the track is never overwritten
  logic [7:0]       pkt_mem [DEPTH];
  logic [LEN_W-1:0] len_mem [SLOTS];

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0] active_r, active_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [LEN_W-1:0]  asm_len_r, asm_len_nxt;
  logic [LEN_W-1:0]  len_rd_r;
  logic [7:0]        rd_byte_r;
  logic              reject, wr_en, commit;
  logic [LEN_W-1:0]  new_len;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [LEN_W-1:0]  rd_ofs;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  // push and pop control
  always_comb begin
    reject      = (count_r == CNT_W'(FIFO_PACKETS)) ||
                  (asm_len_r == LEN_W'(MAX_PACKET_BYTES));
    new_len     = asm_len_r + LEN_W'(1);
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    active_nxt  = active_r;
    count_nxt   = count_r;
    asm_len_nxt = asm_len_r;
    wr_en       = 1'b0;
    commit      = 1'b0;
    push_status = PUSH_NONE;
    priority if (push) begin
      if (reject) begin
        push_status = PUSH_REJECT;
        asm_len_nxt = '0;
      end else begin
        push_status = PUSH_OK;
        wr_en       = 1'b1;
        asm_len_nxt = new_len;
        if (push_last) begin
          commit      = 1'b1;
          tail_nxt    = slot_inc(tail_r);
          count_nxt   = count_r + CNT_W'(1);
          asm_len_nxt = '0;
        end
      end
    end else if (pop && count_r != '0) begin
      head_nxt   = slot_inc(head_r);
      active_nxt = head_r;
      count_nxt  = count_r - CNT_W'(1);
    end
  end

  // byte addresses
  always_comb begin
    rd_ofs  = (rd_idx < LEN_W'(MAX_PACKET_BYTES)) ? rd_idx : '0;
    wr_addr = ADDR_W'(tail_r) * ADDR_W'(MAX_PACKET_BYTES) + ADDR_W'(asm_len_r);
    rd_addr = ADDR_W'(active_r) * ADDR_W'(MAX_PACKET_BYTES) + ADDR_W'(rd_ofs);
  end

  // packet byte store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pkt_mem[wr_addr] <= push_byte;
    end
    rd_byte_r <= pkt_mem[rd_addr];
  end

  // packet length store, with bypass when committing into an empty queue
  always_ff @(posedge clk) begin
    if (commit) begin
      len_mem[tail_r] <= new_len;
    end
    if (commit && tail_r == head_r) begin
      len_rd_r <= new_len;
    end else begin
      len_rd_r <= len_mem[head_r];
    end
  end

  // pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      active_r  <= '0;
      count_r   <= '0;
      asm_len_r <= '0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      active_r  <= active_nxt;
      count_r   <= count_nxt;
      asm_len_r <= asm_len_nxt;
    end
  end

  assign nonempty = (count_r != '0);
  assign head_len = len_rd_r;
  assign rd_byte  = rd_byte_r;

endmodule

>>> rtl/dcc_encoder.sv
module dcc_encoder import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             enable,
  input  logic             drive_mode,
  input  logic [7:0]       one_half,
  input  logic [7:0]       zero_half,
  input  logic [5:0]       preamble_len,
  input  logic             home,
  input  logic             nonempty,
  input  logic [LEN_W-1:0] head_len,
  input  logic [7:0]       rd_byte,
  output logic             pop,
  output logic [LEN_W-1:0] rd_idx,
  output logic             pin_a,
  output logic             pin_b,
  output logic             half_phase,
  output logic             bit_on_track
);

  enc_state_t       state_r, state_nxt;
  logic [5:0]       bit_cnt_r, bit_cnt_nxt;
  logic [LEN_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             cur_bit_r, cur_bit_nxt;
  logic             phase_r, phase_nxt;
  logic [7:0]       timer_r, timer_nxt;
  logic [LEN_W-1:0] act_len_r, act_len_nxt;
  logic             idle_r, idle_nxt;

  // next state: half-bit timing and bit sequencing
  always_comb begin
    logic [7:0]       dur;
    logic [7:0]       t;
    logic [5:0]       pre;
    logic [5:0]       bc;
    logic [7:0]       cur_byte;
    logic [LEN_W-1:0] byte_inc;
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    cur_bit_nxt  = cur_bit_r;
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    act_len_nxt  = act_len_r;
    idle_nxt     = idle_r;
    pop          = 1'b0;
    dur          = cur_bit_r ? one_half : zero_half;
    if (dur == 8'd0) begin
      dur = 8'd1;
    end
    t        = timer_r + 8'd1;
    pre      = (preamble_len == 6'd0) ? 6'd1 : preamble_len;
    bc       = bit_cnt_r + 6'd1;
    cur_byte = idle_r ? idle_byte(int'(byte_cnt_r)) : rd_byte;
    byte_inc = byte_cnt_r + LEN_W'(1);
    priority if (home) begin
      state_nxt    = ST_PREAMBLE;
      bit_cnt_nxt  = '0;
      byte_cnt_nxt = '0;
      cur_bit_nxt  = 1'b1;
      phase_nxt    = 1'b0;
      timer_nxt    = '0;
      act_len_nxt  = LEN_W'(IDLE_LENGTH);
      idle_nxt     = 1'b1;
    end else if (tick && enable) begin
      if (t >= dur || t == 8'd0) begin
        timer_nxt = '0;
        phase_nxt = ~phase_r;
        // entering the first half of a new bit
        if (phase_r) begin
          unique case (state_r)
            ST_PREAMBLE: begin
              cur_bit_nxt = 1'b1;
              bit_cnt_nxt = bc;
              if (bc >= pre || bc == 6'd0) begin
                state_nxt = ST_START;
              end
            end
            ST_START: begin
              cur_bit_nxt  = 1'b0;
              state_nxt    = ST_DATA;
              byte_cnt_nxt = '0;
              bit_cnt_nxt  = '0;
            end
            ST_DATA: begin
              cur_bit_nxt = cur_byte[3'd7 - bit_cnt_r[2:0]];
              bit_cnt_nxt = bc;
              if (bit_cnt_r >= 6'd7) begin
                byte_cnt_nxt = byte_inc;
                state_nxt    = (byte_inc >= act_len_r) ? ST_END : ST_GAP;
              end
            end
            ST_GAP: begin
              cur_bit_nxt = 1'b0;
              state_nxt   = ST_DATA;
              bit_cnt_nxt = '0;
            end
            ST_END: begin
              cur_bit_nxt = 1'b1;
              state_nxt   = ST_PREAMBLE;
              bit_cnt_nxt = '0;
              if (nonempty) begin
                pop      = 1'b1;
                idle_nxt = 1'b0;
                if (head_len == '0) begin
                  act_len_nxt = LEN_W'(1);
                end else if (head_len > LEN_W'(MAX_PACKET_BYTES)) begin
                  act_len_nxt = LEN_W'(MAX_PACKET_BYTES);
                end else begin
                  act_len_nxt = head_len;
                end
              end else begin
                idle_nxt    = 1'b1;
                act_len_nxt = LEN_W'(IDLE_LENGTH);
              end
            end
            default: begin
              state_nxt = ST_PREAMBLE;
            end
          endcase
        end
      end else begin
        timer_nxt = t;
      end
    end
  end

  // pin levels for the current half-bit
  always_comb begin
    pin_a        = enable & ~phase_r;
    pin_b        = enable & (drive_mode | phase_r);
    half_phase   = enable & phase_r;
    bit_on_track = cur_bit_r;
  end

  assign rd_idx = byte_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_PREAMBLE;
      bit_cnt_r  <= '0;
      byte_cnt_r <= '0;
      cur_bit_r  <= 1'b1;
      phase_r    <= 1'b0;
      timer_r    <= '0;
      act_len_r  <= LEN_W'(IDLE_LENGTH);
      idle_r     <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      cur_bit_r  <= cur_bit_nxt;
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      act_len_r  <= act_len_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import dcc_pkg::*;

  localparam int MAXB   = MAX_PACKET_BYTES_DEF;
  localparam int FIFO_N = FIFO_PACKETS_DEF;
  localparam int LIMIT  = 400000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } track_item_t;

  typedef struct packed {
    logic         pin_a;
    logic         pin_b;
    logic         half_phase;
    logic         bit_on_track;
    push_status_t push_status;
    logic [4:0]   queue_used;
  } track_result_t;

  typedef struct packed {
    logic [MAXB*8-1:0] bytes;
    logic [2:0]        len;
  } queued_pkt_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();

  dcc_track_signal_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // register copies held by the predictor
  logic       en_r, mode_r;
  logic [7:0] one_r, zero_r;
  logic [5:0] pre_r;

  // encoder copy
  enc_state_t        enc_st;
  logic [5:0]        bit_cnt;
  logic [2:0]        byte_cnt;
  logic              cur_bit, phase;
  logic [7:0]        half_tmr;
  logic [MAXB*8-1:0] track_buf;
  logic [2:0]        track_len;

  // packet queue and assembly copy
  queued_pkt_t       pkt_q[$];
  logic [MAXB*8-1:0] asm_buf;
  logic [2:0]        asm_len;

  track_item_t   pend_q[$];
  track_result_t track_q[$];

  int n_fail, n_ticks, n_push_ok, n_push_rej, n_sent;
  int burst_left, gap_left, stall_cnt, stall_mode, cycle_cnt;
  track_item_t   nxt;
  track_result_t want;

  // idle packet into the track buffer
  function automatic void load_idle();
    track_buf = '0;
    track_buf[7:0]   = IDLE_BYTE_0;
    track_buf[15:8]  = IDLE_BYTE_1;
    track_buf[23:16] = IDLE_BYTE_2;
    track_len = 3'(IDLE_LENGTH);
  endfunction

  function automatic void encoder_to_start();
    enc_st   = ST_PREAMBLE;
    bit_cnt  = '0;
    byte_cnt = '0;
    cur_bit  = 1'b1;
    phase    = 1'b0;
    half_tmr = '0;
    load_idle();
  endfunction

  // next packet onto the track, idle packet when nothing is queued
  function automatic void take_next_packet();
    queued_pkt_t p;
    if (pkt_q.size() == 0) begin
      load_idle();
    end else begin
      p = pkt_q.pop_front();
      track_buf = p.bytes;
      track_len = p.len;
      n_sent++;
    end
  endfunction

  // choose the bit that starts now
  function automatic void choose_bit();
    logic       nb;
    logic [5:0] pre;
    pre = (pre_r == 0) ? 6'd1 : pre_r;
    nb  = 1'b1;
    case (enc_st)
      ST_PREAMBLE: begin
        nb = 1'b1;
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt >= pre || bit_cnt == 0) enc_st = ST_START;
      end
      ST_START: begin
        nb = 1'b0;
        enc_st = ST_DATA;
        byte_cnt = '0;
        bit_cnt = '0;
      end
      ST_DATA: begin
        nb = track_buf[byte_cnt * 8 + (7 - bit_cnt[2:0])];
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt > 7) begin
          byte_cnt = byte_cnt + 1'b1;
          enc_st = (byte_cnt >= track_len) ? ST_END : ST_GAP;
        end
      end
      ST_GAP: begin
        nb = 1'b0;
        enc_st = ST_DATA;
        bit_cnt = '0;
      end
      default: begin
        nb = 1'b1;
        enc_st = ST_PREAMBLE;
        bit_cnt = '0;
        take_next_packet();
      end
    endcase
    cur_bit = nb;
  endfunction

  // one microsecond of track time
  function automatic void advance_time();
    logic [7:0] dur;
    dur = cur_bit ? one_r : zero_r;
    if (dur == 0) dur = 8'd1;
    half_tmr = half_tmr + 1'b1;
    if (half_tmr >= dur || half_tmr == 0) begin
      half_tmr = '0;
      phase = ~phase;
      if (!phase) choose_bit();
    end
  endfunction

  // expected result of one transaction, state moved on
  function automatic track_result_t track_outcome(logic op, logic [7:0] data, logic last);
    track_result_t r;
    queued_pkt_t   p;
    r = '0;
    if (en_r) begin
      r.half_phase = phase;
      r.pin_a      = ~phase;
      r.pin_b      = mode_r ? 1'b1 : phase;
    end
    r.bit_on_track = cur_bit;
    r.push_status  = PUSH_NONE;
    if (op == OP_TICK) begin
      n_ticks++;
      if (en_r) advance_time();
    end else if (pkt_q.size() >= FIFO_N || asm_len >= MAXB) begin
      asm_len = '0;
      r.push_status = PUSH_REJECT;
      n_push_rej++;
    end else begin
      asm_buf[asm_len * 8 +: 8] = data;
      asm_len = asm_len + 1'b1;
      r.push_status = PUSH_OK;
      n_push_ok++;
      if (last) begin
        p.bytes = asm_buf;
        p.len   = asm_len;
        pkt_q.push_back(p);
        asm_len = '0;
      end
    end
    r.queue_used = 5'(pkt_q.size());
    return r;
  endfunction

  // stimulus helpers
  function automatic void add_push(logic [7:0] data, logic last);
    track_item_t it;
    it.op = OP_PUSH;
    it.data = data;
    it.last = last;
    pend_q.push_back(it);
  endfunction

  function automatic void add_ticks(int n);
    track_item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = OP_TICK;
      it.data = 8'($urandom);
      it.last = 1'($urandom);
      pend_q.push_back(it);
    end
  endfunction

  function automatic void add_packet(int n);
    for (int i = 0; i < n; i++) add_push(8'($urandom), i == n - 1);
  endfunction

  // mostly well-formed packets between runs of ticks, some noise
  function automatic void build_phase(int n_items, int tick_pct);
    int r;
    while (pend_q.size() < n_items) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        add_ticks($urandom_range(1, 24));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) add_packet($urandom_range(1, MAXB));
        else if (r < 85) add_packet($urandom_range(MAXB + 1, MAXB + 2));
        else if (r < 95) for (int k = $urandom_range(1, 4); k > 0; k--) add_push(8'($urandom), 1'b0);
        else add_push(8'($urandom), 1'($urandom));
      end
    end
  endfunction

  // register writes on consecutive edges, only while the block is idle
  task automatic apply_settings(logic en, logic mode, logic [7:0] one, logic [7:0] zero,
                                logic [5:0] pre);
    cfg_index_t idx;
    logic [7:0] val;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: begin idx = CFG_OUTPUT_ENABLE;   val = {7'd0, en};   end
        1: begin idx = CFG_DRIVE_MODE;      val = {7'd0, mode}; end
        2: begin idx = CFG_ONE_HALF_TICKS;  val = one;          end
        3: begin idx = CFG_ZERO_HALF_TICKS; val = zero;         end
        default: begin idx = CFG_PREAMBLE_LENGTH; val = {2'd0, pre}; end
      endcase
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      case (idx)
        CFG_OUTPUT_ENABLE: begin
          en_r = val[0];
          if (!en_r) encoder_to_start();
        end
        CFG_DRIVE_MODE:      mode_r = val[0];
        CFG_ONE_HALF_TICKS:  one_r  = val;
        CFG_ZERO_HALF_TICKS: zero_r = val;
        default:             pre_r  = val[5:0];
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_ch.valid || track_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // main sequence
  initial begin
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_OUTPUT_ENABLE;
    cfg_data        <= 8'h00;
    en_r = 1'b0;
    mode_r = 1'b0;
    one_r = ONE_HALF_RESET;
    zero_r = ZERO_HALF_RESET;
    pre_r = PREAMBLE_RESET;
    encoder_to_start();
    asm_buf = '0;
    asm_len = '0;
    n_fail = 0;
    n_ticks = 0;
    n_push_ok = 0;
    n_push_rej = 0;
    n_sent = 0;
    burst_left = 1;
    gap_left = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: disabled tick, over-long packet, queue filled then one push too many
    add_ticks(1);
    for (int i = 0; i < MAXB; i++) add_push((i % 2) ? 8'hFF : 8'h00, 1'b0);
    add_push(8'hA5, 1'b1);
    for (int i = 0; i < FIFO_N; i++) add_push((i % 2) ? 8'h00 : 8'hFF, 1'b1);
    add_push(8'h5A, 1'b1);
    wait_drained();

    // shortest durations drain the full queue
    apply_settings(1'b1, 1'b0, 8'd1, 8'd1, 6'd1);
    build_phase(150, 60);
    wait_drained();

    apply_settings(1'b1, 1'b1, 8'd2, 8'd3, 6'd4);
    build_phase(200, 55);
    wait_drained();

    // longest durations, then shortened mid half-bit
    apply_settings(1'b1, 1'b0, 8'd255, 8'd255, 6'd63);
    build_phase(60, 90);
    wait_drained();

    apply_settings(1'b1, 1'b1, 8'd1, 8'd2, 6'd2);
    build_phase(200, 50);
    wait_drained();

    // disabled: ticks held, pushes still queue
    apply_settings(1'b0, 1'b0, 8'd3, 8'd4, 6'd5);
    build_phase(100, 50);
    wait_drained();

    // zero durations and zero preamble act as one
    apply_settings(1'b1, 1'b0, 8'd0, 8'd0, 6'd0);
    build_phase(150, 65);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      apply_settings(1'b1, 1'($urandom), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                     6'($urandom_range(1, 12)));
      build_phase(150, $urandom_range(50, 70));
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d ticks, %0d bytes taken, %0d pushes rejected, %0d queued packets sent",
             n_ticks, n_push_ok, n_push_rej, n_sent);
    $display("durations 0 to 255, preambles 0 to 63, both drive modes and a disabled spell");
    if (n_fail == 0) begin
      $display("[dcc_track_signal_generator] OK");
    end else begin
      $display("[dcc_track_signal_generator] ERROR");
    end
    $finish;
  end

  // driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.op        <= OP_TICK;
      in_ch.data_byte <= 8'h00;
      in_ch.last_byte <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_q.push_back(track_outcome(in_ch.op, in_ch.data_byte, in_ch.last_byte));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.op        <= nxt.op;
          in_ch.data_byte <= nxt.data;
          in_ch.last_byte <= nxt.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with its mode chosen at random
  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= stall_cnt[1];
      default: out_ch.ready <= 1'($urandom);
    endcase
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // monitor: each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (track_q.size() == 0) begin
        $error("result transaction with nothing expected");
        n_fail++;
      end else begin
        want = track_q.pop_front();
        check_field("pin_a", 8'(want.pin_a), 8'(out_ch.pin_a));
        check_field("pin_b", 8'(want.pin_b), 8'(out_ch.pin_b));
        check_field("half_phase", 8'(want.half_phase), 8'(out_ch.half_phase));
        check_field("bit_on_track", 8'(want.bit_on_track), 8'(out_ch.bit_on_track));
        check_field("push_status", 8'(want.push_status), 8'(out_ch.push_status));
        check_field("queue_used", 8'(want.queue_used), 8'(out_ch.queue_used));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("[dcc_track_signal_generator] ERROR");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/dcc_pkg.sv
rtl/dcc_if.sv
rtl/dcc_fifo.sv
rtl/dcc_encoder.sv
rtl/dcc_track_signal_generator.sv
verif/tb.sv
